### rtl/dfpx_pkg.sv
// Shared types and constants for the delimited frame parser with XOR check.
package dfpx_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned PosW  = 9;
    localparam int unsigned StatW = 9;

    // Configuration register indexes
    localparam logic [1:0] CFG_START_DELIM = 2'd0;
    localparam logic [1:0] CFG_END_DELIM   = 2'd1;
    localparam logic [1:0] CFG_MAX_LENGTH  = 2'd2;

    // Byte positions within a frame, counted from the start delimiter
    localparam logic [PosW-1:0] POS_START   = 9'd0;
    localparam logic [PosW-1:0] POS_LENGTH  = 9'd1;
    localparam logic [PosW-1:0] POS_DEVICE  = 9'd2;
    localparam logic [PosW-1:0] POS_CODE    = 9'd3;
    localparam logic [PosW-1:0] POS_ID      = 9'd4;
    localparam logic [PosW-1:0] POS_PAYLOAD = 9'd5;
    localparam logic [PosW-1:0] POS_MAX     = 9'd511;

    localparam logic signed [StatW-1:0] STATUS_ERR = -9'sd1;
    localparam logic signed [StatW-1:0] STATUS_OK  = 9'sd0;

    typedef struct packed {
        logic [ByteW-1:0] start_delim;
        logic [ByteW-1:0] end_delim;
        logic [ByteW-1:0] max_length;
    } t_cfg;

    typedef struct packed {
        logic signed [StatW-1:0] status;
        logic                    in_frame;
        logic                    payload_valid;
        logic [ByteW-1:0]        payload_index;
        logic [ByteW-1:0]        payload_byte;
        logic [ByteW-1:0]        frame_length;
        logic [ByteW-1:0]        node_id;
        logic [ByteW-1:0]        frame_code;
        logic [ByteW-1:0]        frame_id;
    } t_result;

endpackage

### rtl/dfpx_core.sv
// Frame parse state and its per-byte update.
module dfpx_core
    import dfpx_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [ByteW-1:0] i_rx_byte,
    input  t_cfg             i_cfg,
    output t_result          o_result
);

    logic [PosW-1:0]         r_position, n_position;
    logic                    r_synced,   n_synced;
    logic [ByteW-1:0]        r_length,   n_length;
    logic [ByteW-1:0]        r_device,   n_device;
    logic [ByteW-1:0]        r_code,     n_code;
    logic [ByteW-1:0]        r_id,       n_id;
    logic [ByteW-1:0]        r_xor,      n_xor;
    logic signed [StatW-1:0] r_status,   n_status;

    logic            is_start;
    logic            process;
    logic [PosW-1:0] pos_eff;
    logic [PosW-1:0] k;
    logic [PosW-1:0] len_ext;
    logic            pvalid;
    logic [ByteW-1:0] pidx;
    logic [ByteW-1:0] pbyte;

    always_comb begin
        is_start   = (i_rx_byte == i_cfg.start_delim);
        process    = is_start || r_synced;
        pos_eff    = is_start ? POS_START : r_position;
        k          = pos_eff - POS_PAYLOAD;
        len_ext    = {1'b0, r_length};
        n_position = r_position;
        n_synced   = r_synced || is_start;
        n_length   = r_length;
        n_device   = r_device;
        n_code     = r_code;
        n_id       = r_id;
        n_xor      = r_xor;
        n_status   = r_status;
        pvalid     = 1'b0;
        pidx       = '0;
        pbyte      = '0;
        if (process) begin
            case (pos_eff)
                POS_START: begin
                    n_xor = '0;
                end
                POS_LENGTH: begin
                    n_length = i_rx_byte;
                    if (i_rx_byte > i_cfg.max_length) begin
                        n_status = STATUS_ERR;
                    end
                end
                POS_DEVICE: begin
                    n_device = i_rx_byte;
                    n_xor    = r_xor ^ i_rx_byte;
                end
                POS_CODE: begin
                    n_code = i_rx_byte;
                    n_xor  = r_xor ^ i_rx_byte;
                end
                POS_ID: begin
                    n_id  = i_rx_byte;
                    n_xor = r_xor ^ i_rx_byte;
                end
                default: begin
                    if (k < len_ext) begin
                        pvalid = 1'b1;
                        pidx   = k[ByteW-1:0];
                        pbyte  = i_rx_byte;
                        n_xor  = r_xor ^ i_rx_byte;
                    end else begin
                        n_status = STATUS_ERR;
                        if (k == len_ext) begin
                            if (i_rx_byte == i_cfg.end_delim) begin
                                n_status = $signed({1'b0, r_code});
                            end else if (i_rx_byte == r_xor) begin
                                n_status = STATUS_OK;
                            end
                        end else if ((k == len_ext + 9'd1) &&
                                     (i_rx_byte == i_cfg.end_delim)) begin
                            n_status = $signed({1'b0, r_code});
                        end
                    end
                end
            endcase
            // saturate the position counter
            n_position = (pos_eff < POS_MAX) ? pos_eff + 9'd1 : pos_eff;
        end
    end

    always_comb begin
        o_result.status        = n_status;
        o_result.in_frame      = n_synced;
        o_result.payload_valid = pvalid;
        o_result.payload_index = pidx;
        o_result.payload_byte  = pbyte;
        o_result.frame_length  = n_length;
        o_result.node_id       = n_device;
        o_result.frame_code    = n_code;
        o_result.frame_id      = n_id;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_synced   <= 1'b0;
            r_length   <= '0;
            r_device   <= '0;
            r_code     <= '0;
            r_id       <= '0;
            r_xor      <= '0;
            r_status   <= STATUS_OK;
        end else if (i_accept) begin
            r_position <= n_position;
            r_synced   <= n_synced;
            r_length   <= n_length;
            r_device   <= n_device;
            r_code     <= n_code;
            r_id       <= n_id;
            r_xor      <= n_xor;
            r_status   <= n_status;
        end
    end

endmodule

### rtl/delimited_frame_parser_xor_check.sv
// Delimited frame parser with XOR check: top level with config and output buffer.
//
// Takes one received byte per transfer and parses frames of the form start
// delimiter, length, device id, code, frame id, payload, XOR checksum, end
// delimiter. Every accepted byte yields exactly one result transfer carrying
// the status (-1 error, 0 clear or checksum ok, else the code of a completed
// frame), the sync flag, the payload byte with its index when the byte was
// payload, and the current header fields. A start delimiter always restarts
// the frame; bytes before the first one change nothing. The block takes one
// byte every cycle while its input is not stalled: the whole per-byte update
// is a single compare/XOR step between the state registers and the result
// register. A two-entry output buffer (result register plus skid register)
// lets the input accept one more byte after the output side stalls, parking
// its result in the skid register; the input stall is taken straight from the
// skid register. Configuration registers (start delimiter, end delimiter,
// maximum payload length) are written through a separate always-ready port
// and should only change while no byte is in flight.
module delimited_frame_parser_xor_check
    import dfpx_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // byte input channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [ByteW-1:0]        i_rx_byte,
    // result channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [StatW-1:0] o_status,
    output logic                    o_in_frame,
    output logic                    o_payload_valid,
    output logic [ByteW-1:0]        o_payload_index,
    output logic [ByteW-1:0]        o_payload_byte,
    output logic [ByteW-1:0]        o_frame_length,
    output logic [ByteW-1:0]        o_node_id,
    output logic [ByteW-1:0]        o_frame_code,
    output logic [ByteW-1:0]        o_frame_id,
    // configuration write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [ByteW-1:0]        i_cfg_data
);

    t_cfg    r_cfg;
    t_result core_result;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    in_xfer;
    logic    out_free;

    // Config port never backs up.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_delim <= 8'd35;
            r_cfg.end_delim   <= 8'd45;
            r_cfg.max_length  <= 8'd70;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_DELIM: r_cfg.start_delim <= i_cfg_data;
                CFG_END_DELIM:   r_cfg.end_delim   <= i_cfg_data;
                CFG_MAX_LENGTH:  r_cfg.max_length  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Stall input only while the skid entry is occupied.
    assign o_in_stall = r_skid_valid;
    assign in_xfer    = i_in_valid && !r_skid_valid;
    // Result register can load when empty or being drained this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;

    dfpx_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_xfer),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (r_cfg),
        .o_result  (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            // advance: skid entry is older, so it goes first
            r_out_valid  <= r_skid_valid || in_xfer;
            r_skid_valid <= 1'b0;
        end else if (in_xfer) begin
            // output held: park the new result in the skid register
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : core_result;
        end else if (in_xfer) begin
            r_skid <= core_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_in_frame      = r_out.in_frame;
    assign o_payload_valid = r_out.payload_valid;
    assign o_payload_index = r_out.payload_index;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_frame_length  = r_out.frame_length;
    assign o_node_id       = r_out.node_id;
    assign o_frame_code    = r_out.frame_code;
    assign o_frame_id      = r_out.frame_id;

    // Skid entry is only ever filled behind a held result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("skid entry occupied with empty result register");

    // Payload is reported only after sync.
    a_payload_synced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_payload_valid) |-> o_in_frame)
        else $error("payload byte reported before start delimiter");

    // Non-payload results carry zero index and byte.
    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_payload_valid) |->
            (o_payload_index == 8'd0 && o_payload_byte == 8'd0))
        else $error("payload fields nonzero on non-payload result");

    // A byte transferred behind a held result is parked in the skid entry.
    a_accept_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && o_out_valid && i_out_stall) |=> o_in_stall)
        else $error("byte transferred behind held result was not parked");

endmodule

### tb/delimited_frame_parser_xor_check_test.sv
// Self-checking testbench for the delimited frame parser with XOR check.
`timescale 1ns / 1ps

module delimited_frame_parser_xor_check_test
    import dfpx_pkg::*;
();

    localparam int CLK_PERIOD_NS  = 4;
    localparam int RESET_CYCLES   = 10;
    localparam int IDLE_PERCENT   = 17;
    localparam int CALM_WINDOW    = 1500;  // every window ends in a stretch without idling
    localparam int CALM_FROM      = 1150;
    localparam int LONG_HOLD      = 80;    // receiver hold-off, long enough to back up the input
    localparam int HOLD_AT_A      = 350;
    localparam int HOLD_AT_B      = 1300;
    localparam int DRAIN_CYCLES   = 4;     // result register plus skid register, with margin
    localparam int WATCHDOG_LIMIT = 2000;

    // Register values after reset
    localparam logic [ByteW-1:0] RST_START_DELIM = 8'd35;
    localparam logic [ByteW-1:0] RST_END_DELIM   = 8'd45;
    localparam logic [ByteW-1:0] RST_MAX_LENGTH  = 8'd70;

    // Index with no register behind it; a write there must change nothing
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic [ByteW-1:0]        i_rx_byte   = '0;
    logic                    i_out_stall = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic [1:0]              i_cfg_index = '0;
    logic [ByteW-1:0]        i_cfg_data  = '0;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic signed [StatW-1:0] o_status;
    logic                    o_in_frame;
    logic                    o_payload_valid;
    logic [ByteW-1:0]        o_payload_index;
    logic [ByteW-1:0]        o_payload_byte;
    logic [ByteW-1:0]        o_frame_length;
    logic [ByteW-1:0]        o_node_id;
    logic [ByteW-1:0]        o_frame_code;
    logic [ByteW-1:0]        o_frame_id;
    logic                    o_cfg_ready;

    // Bytes waiting to be offered, and the parser outputs expected per accepted byte
    logic [ByteW-1:0] rx_stream_q[$];
    t_result          parser_view_q[$];

    // Tracked copy of the parser state and its registers
    t_cfg                    trk_cfg;
    logic [PosW-1:0]         trk_pos;
    logic                    trk_synced;
    logic [ByteW-1:0]        trk_len;
    logic [ByteW-1:0]        trk_dev;
    logic [ByteW-1:0]        trk_code;
    logic [ByteW-1:0]        trk_id;
    logic [ByteW-1:0]        trk_xor;
    logic signed [StatW-1:0] trk_status;

    int n_queued    = 0;
    int n_bytes     = 0;
    int n_results   = 0;
    int n_cfg       = 0;
    int n_settings  = 1;
    int n_starts    = 0;
    int n_closed    = 0;
    int n_sum_ok    = 0;
    int n_err_marks = 0;
    int n_errors    = 0;
    int hold_left   = 0;
    int cyc         = 0;
    int idle_cycles = 0;

    // Idling is switched off for the last part of every window
    wire calm  = (cyc % CALM_WINDOW) >= CALM_FROM;
    wire moved = (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                 || (i_cfg_valid && o_cfg_ready);

    delimited_frame_parser_xor_check u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_in_frame      (o_in_frame),
        .o_payload_valid (o_payload_valid),
        .o_payload_index (o_payload_index),
        .o_payload_byte  (o_payload_byte),
        .o_frame_length  (o_frame_length),
        .o_node_id       (o_node_id),
        .o_frame_code    (o_frame_code),
        .o_frame_id      (o_frame_id),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #(CLK_PERIOD_NS / 2) i_clk = ~i_clk;

    initial begin
        trk_cfg.start_delim = RST_START_DELIM;
        trk_cfg.end_delim   = RST_END_DELIM;
        trk_cfg.max_length  = RST_MAX_LENGTH;
        trk_pos    = POS_START;
        trk_synced = 1'b0;
        trk_len    = '0;
        trk_dev    = '0;
        trk_code   = '0;
        trk_id     = '0;
        trk_xor    = '0;
        trk_status = STATUS_OK;
    end

    // Advance the tracked parser by one accepted byte and queue the outputs it must show
    function automatic void parse_byte(input logic [ByteW-1:0] b);
        t_result         view;
        logic            live;
        logic [PosW-1:0] k;
        view = '0;
        live = 1'b1;
        if (b == trk_cfg.start_delim) begin
            // a start byte always wins, even over an equal end delimiter
            trk_synced = 1'b1;
            trk_pos    = POS_START;
            n_starts++;
        end else if (!trk_synced) begin
            live = 1'b0;
        end
        if (live) begin
            case (trk_pos)
                POS_START: trk_xor = '0;
                POS_LENGTH: begin
                    trk_len = b;
                    if (b > trk_cfg.max_length) begin
                        trk_status = STATUS_ERR;
                        n_err_marks++;
                    end
                end
                POS_DEVICE: begin
                    trk_dev = b;
                    trk_xor = trk_xor ^ b;
                end
                POS_CODE: begin
                    trk_code = b;
                    trk_xor  = trk_xor ^ b;
                end
                POS_ID: begin
                    trk_id  = b;
                    trk_xor = trk_xor ^ b;
                end
                default: begin
                    k = trk_pos - POS_PAYLOAD;
                    if (k < {1'b0, trk_len}) begin
                        view.payload_valid = 1'b1;
                        view.payload_index = k[ByteW-1:0];
                        view.payload_byte  = b;
                        trk_xor = trk_xor ^ b;
                    end else begin
                        // past the payload: error unless the checksum slot
                        // or the slot after it closes the frame
                        trk_status = STATUS_ERR;
                        if (k == {1'b0, trk_len}) begin
                            if (b == trk_cfg.end_delim) begin
                                trk_status = $signed({1'b0, trk_code});
                            end else if (b == trk_xor) begin
                                trk_status = STATUS_OK;
                            end
                        end else if (k == {1'b0, trk_len} + 9'd1 && b == trk_cfg.end_delim) begin
                            trk_status = $signed({1'b0, trk_code});
                        end
                        if (trk_status == STATUS_ERR) n_err_marks++;
                        else if (trk_status == STATUS_OK) n_sum_ok++;
                        else n_closed++;
                    end
                end
            endcase
            // saturate; every byte at the top position counts as an overrun
            if (trk_pos != POS_MAX) trk_pos = trk_pos + 9'd1;
        end
        view.status        = trk_status;
        view.in_frame      = trk_synced;
        view.frame_length  = trk_len;
        view.node_id       = trk_dev;
        view.frame_code    = trk_code;
        view.frame_id      = trk_id;
        parser_view_q.push_back(view);
    endfunction

    task automatic check_field(input string name, input int expv, input int actv);
        if (expv != actv) begin
            $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
            n_errors++;
        end
    endtask

    // Compare one result transfer with the oldest pending expectation
    task automatic compare_view();
        t_result want;
        n_results++;
        if (parser_view_q.size() == 0) begin
            $error("result transfer with no byte pending: status %0d", o_status);
            n_errors++;
        end else begin
            want = parser_view_q.pop_front();
            check_field("status",        want.status,        o_status);
            check_field("in_frame",      want.in_frame,      o_in_frame);
            check_field("payload_valid", want.payload_valid, o_payload_valid);
            check_field("payload_index", want.payload_index, o_payload_index);
            check_field("payload_byte",  want.payload_byte,  o_payload_byte);
            check_field("frame_length",  want.frame_length,  o_frame_length);
            check_field("node_id",       want.node_id,       o_node_id);
            check_field("frame_code",    want.frame_code,    o_frame_code);
            check_field("frame_id",      want.frame_id,      o_frame_id);
        end
    endtask

    // Byte driver: pop a byte when it transfers, hold it while stalled, idle at random
    always @(posedge i_clk) begin : byte_driver
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                parse_byte(rx_stream_q.pop_front());
                n_bytes++;
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (rx_stream_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
                    i_in_valid <= 1'b1;
                    i_rx_byte  <= rx_stream_q[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check every transfer, stall at random, and twice hold off
    // for a long stretch so the block backs up and stalls its input
    always @(posedge i_clk) begin : result_monitor
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                compare_view();
                if (n_results == HOLD_AT_A || n_results == HOLD_AT_B) hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    // Watchdog: end the run when no transfer of any kind happens for too long
    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            cyc <= cyc + 1;
            if (moved) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic put(input logic [ByteW-1:0] b);
        rx_stream_q.push_back(b);
        n_queued++;
    endtask

    function automatic logic [ByteW-1:0] body_byte();
        logic [ByteW-1:0] b;
        do begin
            b = 8'($urandom_range(255));
        end while (b == trk_cfg.start_delim);
        return b;
    endfunction

    // Write one register; track it at the edge where the write lands
    task automatic write_reg(input logic [1:0] idx, input logic [ByteW-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_START_DELIM: trk_cfg.start_delim = val;
            CFG_END_DELIM:   trk_cfg.end_delim   = val;
            CFG_MAX_LENGTH:  trk_cfg.max_length  = val;
            default: ;
        endcase
        n_cfg++;
    endtask

    task automatic apply_setting(input logic [ByteW-1:0] sd, input logic [ByteW-1:0] ed,
                                 input logic [ByteW-1:0] ml);
        write_reg(CFG_START_DELIM, sd);
        write_reg(CFG_END_DELIM, ed);
        write_reg(CFG_MAX_LENGTH, ml);
        n_settings++;
    endtask

    // Hold the sender until every byte has transferred and every result has come back
    task automatic wait_drained();
        while (rx_stream_q.size() != 0 || parser_view_q.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One frame with random content; mostly well formed, the rest broken on purpose
    task automatic queue_random_frame();
        int unsigned      pick;
        int unsigned      plen;
        int unsigned      cut;
        logic             oversize;
        logic [ByteW-1:0] sum;
        logic [ByteW-1:0] b;
        oversize = 1'b0;
        pick = $urandom_range(99);
        if (pick < 3) begin
            plen = trk_cfg.max_length;
        end else if (pick < 10 && trk_cfg.max_length != 8'hFF) begin
            plen = $urandom_range(trk_cfg.max_length + 1, 255);
            oversize = 1'b1;
        end else begin
            plen = $urandom_range(0, (trk_cfg.max_length < 8) ? trk_cfg.max_length : 8);
        end
        // line noise ahead of the frame, start bytes included
        if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(1, 3)) put(8'($urandom_range(255)));
        end
        put(trk_cfg.start_delim);
        put(plen[ByteW-1:0]);
        sum = '0;
        repeat (3) begin
            b = body_byte();
            sum = sum ^ b;
            put(b);
        end
        // an oversized frame is cut short and restarted by the next start byte
        cut = oversize ? $urandom_range(0, 4) : plen;
        for (int unsigned i = 0; i < plen; i++) begin
            if (i == cut) return;
            b = body_byte();
            sum = sum ^ b;
            put(b);
        end
        pick = $urandom_range(99);
        if (pick < 55) begin
            put(sum);
            put(trk_cfg.end_delim);
        end else if (pick < 65) begin
            put(trk_cfg.end_delim);
        end else if (pick < 75) begin
            put(sum ^ 8'($urandom_range(1, 255)));
            put(trk_cfg.end_delim);
        end else if (pick < 85) begin
            put(sum);
            repeat ($urandom_range(1, 4)) put(body_byte());
        end else if (pick < 92) begin
            // drop the tail; the next frame restarts mid-parse
        end else begin
            put(sum);
            put(trk_cfg.end_delim);
            put(trk_cfg.end_delim);
        end
    endtask

    task automatic queue_random_run(input int n_items);
        int stop_at;
        stop_at = n_queued + n_items;
        while (n_queued < stop_at) queue_random_frame();
    endtask

    // Longest legal payload, then keep going until the position counter saturates
    task automatic queue_long_run();
        put(trk_cfg.start_delim);
        put(8'hFF);
        repeat (3 + 520) put(body_byte());
    endtask

    initial begin : stimulus
        logic [ByteW-1:0] sd;
        logic [ByteW-1:0] ed;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sd = trk_cfg.start_delim;
        ed = trk_cfg.end_delim;
        // bytes before the first start byte change nothing
        put(8'h00); put(8'hFF); put(ed);
        // no payload, matching checksum, end delimiter
        put(sd); put(8'h00); put(8'hFF); put(8'h80); put(8'h01); put(8'h7E); put(ed);
        // end delimiter in the checksum slot
        put(sd); put(8'h00); put(8'h11); put(8'h22); put(8'h33); put(ed);
        // length one above the limit, then restart
        put(sd); put(8'd71); put(sd);
        // one payload byte, bad checksum, stray byte after it, then an overrun
        put(8'h01); put(8'h00); put(8'hC3); put(8'h00); put(8'hFF); put(8'h00);
        put(8'h10); put(ed);
        queue_random_run(260);

        wait_drained();
        apply_setting(8'h00, 8'hFF, 8'hFF);
        queue_long_run();
        queue_random_run(240);

        wait_drained();
        apply_setting(8'hFF, 8'h00, 8'h00);
        write_reg(CFG_UNUSED, 8'hA5);
        queue_random_run(260);

        // start and end delimiter equal: the start byte must win
        wait_drained();
        apply_setting(8'h7E, 8'h7E, 8'h10);
        queue_random_run(260);

        wait_drained();
        apply_setting(RST_START_DELIM, RST_END_DELIM, RST_MAX_LENGTH);
        queue_random_run(260);

        wait_drained();
        if (parser_view_q.size() != 0) begin
            $error("%0d expected results never arrived", parser_view_q.size());
            n_errors++;
        end
        $display("run: %0d bytes, %0d results, %0d register writes over %0d settings",
                 n_bytes, n_results, n_cfg, n_settings);
        $display("frames: %0d starts, %0d closed by end delimiter, %0d checksum matches, %0d errors",
                 n_starts, n_closed, n_sum_ok, n_err_marks);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
